// ----- hw/rtl/ilid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ilid_pkg
// Shared types and constants for the indexed list block.
// -----------------------------------------------------------------------------
package ilid_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int CMD_W   = 3;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	// taps per first-level group of the read tree
	localparam int GROUP_SIZE = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ       = 3'd0,
		CMD_INS_HEAD   = 3'd1,
		CMD_APPEND     = 3'd2,
		CMD_INS_AT     = 3'd3,
		CMD_DELETE     = 3'd4
	} cmd_t;

	typedef struct packed {
		logic                      ins;
		logic                      del;
		logic signed [VALUE_W-1:0] new_value;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ilid_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ilid_req_if / ilid_rsp_if
// Valid/ready channels carrying command items and result items.
// -----------------------------------------------------------------------------
interface ilid_req_if;
	logic                               valid;
	logic                               ready;
	logic [ilid_pkg::CMD_W-1:0]         cmd;
	logic [ilid_pkg::POS_W-1:0]         position;
	logic signed [ilid_pkg::VALUE_W-1:0] new_value;

	modport source (output valid, output cmd, output position, output new_value,
		input ready);
	modport sink (input valid, input cmd, input position, input new_value,
		output ready);
endinterface

interface ilid_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [ilid_pkg::VALUE_W-1:0] read_value;
	logic                               accepted;
	logic [ilid_pkg::COUNT_W-1:0]       entry_count;

	modport source (output valid, output read_value, output accepted,
		output entry_count, input ready);
	modport sink (input valid, input read_value, input accepted,
		input entry_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ilid_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ilid_cell
// One list slot: holds an entry and takes it from a neighbor or the input.
// -----------------------------------------------------------------------------
module ilid_cell #(
	parameter int IW  = 7,
	parameter int IDX = 0
) (
	input  wire                                 clk,
	input  wire  ilid_pkg::cell_ctrl_t          ctrl,
	input  wire  [IW-1:0]                       pos,
	input  wire  signed [ilid_pkg::VALUE_W-1:0] left_val,
	input  wire  signed [ilid_pkg::VALUE_W-1:0] right_val,
	output logic signed [ilid_pkg::VALUE_W-1:0] value,
	output logic signed [ilid_pkg::VALUE_W-1:0] tap
);

	localparam logic [IW-1:0] IDX_C = IW'(IDX);

	logic signed [ilid_pkg::VALUE_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			// open a gap at pos: cells above take from below
			if (IDX_C > pos) begin
				value_q <= left_val;
			end else if (IDX_C == pos) begin
				value_q <= ctrl.new_value;
			end
		end else if (ctrl.del && (IDX_C >= pos)) begin
			value_q <= right_val;
		end
	end

	assign value = value_q;
	assign tap   = (IDX_C == pos) ? value_q : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/indexed_list_insert_delete.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of signed 32-bit entries held in a shifting row of cells.
// -----------------------------------------------------------------------------
// Usage:
//   req carries one command item (cmd, position, new_value); rsp returns one
//   result item per command (read_value, accepted, entry_count).
//   Commands: read, insert at head, append, insert before a position and
//   delete at a position. Inserts and deletes shift the cells at and above
//   the target position in the cycle the item is taken.
//   Each item passes the group registers of the read tree, then the output
//   register. The read path is a registered OR tree over the cell taps
//   (groups of 8, then one final level), and a new item is taken only once
//   the previous one has reached the output register.
//   Reset clears the entry count and all handshake state; cell contents are
//   not cleared since only positions below the count are ever read.
//   When rsp stalls, the result holds in the output register and req.ready
//   stays low until it is taken.
// -----------------------------------------------------------------------------
module indexed_list_insert_delete #(
	parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	ilid_req_if.sink     req,
	ilid_rsp_if.source   rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;
	localparam int GS = ilid_pkg::GROUP_SIZE;
	localparam int NG = (CAPACITY + GS - 1) / GS;
	localparam int VW = ilid_pkg::VALUE_W;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0] count_q;
	logic          pend_s1;
	logic          out_valid_q;

	logic signed [VW-1:0]              read_value_q;
	logic                              accepted_q;
	logic [ilid_pkg::COUNT_W-1:0]      entry_count_q;

	logic                 is_read_s1;
	logic                 rd_ok_s1;
	logic                 ok_s1;
	logic [CW-1:0]        count_s1;
	logic signed [VW-1:0] grp_s1 [NG];

	logic                 fire;
	logic                 full;
	logic [IW-1:0]        pos_x;
	logic [IW-1:0]        count_x;
	logic [IW-1:0]        eff_pos;
	logic                 ins_ok;
	logic                 del_ok;
	logic                 rd_ok;
	logic                 ok;
	logic [CW-1:0]        count_d;
	ilid_pkg::cell_ctrl_t ctrl;
	logic signed [VW-1:0] tree_out;

	logic signed [VW-1:0] cell_val [CAPACITY];
	logic signed [VW-1:0] cell_tap [CAPACITY];
	logic signed [VW-1:0] grp_d    [NG];

	assign req.ready = !pend_s1 && (!out_valid_q || rsp.ready);
	assign fire      = req.valid && req.ready;

	assign full    = (count_q == CAP_C);
	assign pos_x   = IW'(req.position);
	assign count_x = IW'(count_q);

	always_comb begin
		ins_ok  = 1'b0;
		del_ok  = 1'b0;
		rd_ok   = 1'b0;
		eff_pos = pos_x;
		unique case (req.cmd)
			ilid_pkg::CMD_READ: begin
				rd_ok = (pos_x < count_x);
			end
			ilid_pkg::CMD_INS_HEAD: begin
				eff_pos = '0;
				ins_ok  = !full;
			end
			ilid_pkg::CMD_APPEND: begin
				eff_pos = count_x;
				ins_ok  = !full;
			end
			ilid_pkg::CMD_INS_AT: begin
				ins_ok = !full && (pos_x <= count_x);
			end
			ilid_pkg::CMD_DELETE: begin
				del_ok = (pos_x < count_x);
			end
			default: begin
			end
		endcase
	end

	assign ok = ins_ok || del_ok || rd_ok;

	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CW'(1);
		end else if (del_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	assign ctrl.ins       = fire && ins_ok;
	assign ctrl.del       = fire && del_ok;
	assign ctrl.new_value = req.new_value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VW-1:0] left_val;
		logic signed [VW-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end

		ilid_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.pos       (eff_pos),
			.left_val  (left_val),
			.right_val (right_val),
			.value     (cell_val[i]),
			.tap       (cell_tap[i])
		);
	end

	// first level of the read tree: OR of the taps in each group
	for (genvar g = 0; g < NG; g++) begin : g_grp
		always_comb begin
			grp_d[g] = '0;
			for (int j = 0; j < GS; j++) begin
				if (g * GS + j < CAPACITY) begin
					grp_d[g] = grp_d[g] | cell_tap[g * GS + j];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (fire) begin
				grp_s1[g] <= grp_d[g];
			end
		end
	end

	always_comb begin
		tree_out = '0;
		for (int g = 0; g < NG; g++) begin
			tree_out = tree_out | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			is_read_s1 <= (req.cmd == ilid_pkg::CMD_READ);
			rd_ok_s1   <= rd_ok;
			ok_s1      <= ok;
			count_s1   <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
			end
			pend_s1 <= fire;
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register is always free when the pending item arrives
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			if (rd_ok_s1) begin
				read_value_q <= tree_out;
			end else if (is_read_s1) begin
				read_value_q <= -32'sd1;
			end else begin
				read_value_q <= '0;
			end
			accepted_q    <= ok_s1;
			entry_count_q <= ilid_pkg::COUNT_W'(count_s1);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.accepted    = accepted_q;
	assign rsp.entry_count = entry_count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_pend_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> out_valid_q)
		else $error("pending item did not reach the output register");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !req.ready)
		else $error("second item taken while one is in flight");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> $stable(count_q))
		else $error("list changed while a result was stalled");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("output register busy when pending item arrived");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed list block: a directed command table,
// a fill to capacity, then random command streams under varying backpressure,
// each result compared against its table entry or a behavioral list kept in the bench.
// -----------------------------------------------------------------------------
module testbench;

	localparam int CAPACITY = ilid_pkg::CAPACITY_DEF;

	localparam logic [ilid_pkg::POS_W-1:0] POS_CAP  = CAPACITY[ilid_pkg::POS_W-1:0];
	localparam logic [ilid_pkg::POS_W-1:0] POS_LAST = POS_CAP - 1'b1;

	// command codes outside the defined set
	localparam logic [ilid_pkg::CMD_W-1:0] CMD_BAD_LO  = 3'd5;
	localparam logic [ilid_pkg::CMD_W-1:0] CMD_BAD_MID = 3'd6;
	localparam logic [ilid_pkg::CMD_W-1:0] CMD_BAD_HI  = 3'd7;

	localparam logic [ilid_pkg::VALUE_W-1:0] V_MAX  = 32'h7FFF_FFFF;
	localparam logic [ilid_pkg::VALUE_W-1:0] V_MIN  = 32'h8000_0000;
	localparam logic [ilid_pkg::VALUE_W-1:0] V_NEG1 = 32'hFFFF_FFFF;
	localparam logic [ilid_pkg::VALUE_W-1:0] V_MID  = 32'h1234_5678;

	typedef struct packed {
		logic signed [ilid_pkg::VALUE_W-1:0] read_value;
		logic                                accepted;
		logic [ilid_pkg::COUNT_W-1:0]        entry_count;
	} list_result_t;

	typedef struct packed {
		logic [ilid_pkg::CMD_W-1:0]   op;
		logic [ilid_pkg::POS_W-1:0]   pos;
		logic [ilid_pkg::VALUE_W-1:0] val;
		logic                         typed;
		list_result_t                 want;
	} stim_row_t;

	// list built up: [V_MAX, V_MID, V_MIN, -1], then head insert of 0
	localparam stim_row_t DIRECTED [25] = '{
		'{ilid_pkg::CMD_READ,     7'd0,   32'd0,  1'b1, '{V_NEG1, 1'b0, 7'd0}},
		'{ilid_pkg::CMD_DELETE,   7'd0,   32'd0,  1'b1, '{32'd0,  1'b0, 7'd0}},
		'{ilid_pkg::CMD_INS_AT,   7'd1,   V_MAX,  1'b1, '{32'd0,  1'b0, 7'd0}},
		'{CMD_BAD_LO,             7'd0,   V_MAX,  1'b1, '{32'd0,  1'b0, 7'd0}},
		'{CMD_BAD_HI,             7'd127, V_NEG1, 1'b1, '{32'd0,  1'b0, 7'd0}},
		'{ilid_pkg::CMD_INS_HEAD, 7'd0,   V_MAX,  1'b1, '{32'd0,  1'b1, 7'd1}},
		'{ilid_pkg::CMD_APPEND,   7'd127, V_MIN,  1'b1, '{32'd0,  1'b1, 7'd2}},
		'{ilid_pkg::CMD_INS_AT,   7'd2,   V_NEG1, 1'b1, '{32'd0,  1'b1, 7'd3}},
		'{ilid_pkg::CMD_INS_AT,   7'd1,   V_MID,  1'b1, '{32'd0,  1'b1, 7'd4}},
		'{ilid_pkg::CMD_INS_HEAD, 7'd127, 32'd0,  1'b1, '{32'd0,  1'b1, 7'd5}},
		'{ilid_pkg::CMD_READ,     7'd0,   V_MAX,  1'b1, '{32'd0,  1'b1, 7'd5}},
		'{ilid_pkg::CMD_READ,     7'd1,   32'd0,  1'b1, '{V_MAX,  1'b1, 7'd5}},
		'{ilid_pkg::CMD_READ,     7'd4,   32'd0,  1'b1, '{V_NEG1, 1'b1, 7'd5}},
		'{ilid_pkg::CMD_READ,     7'd5,   32'd0,  1'b1, '{V_NEG1, 1'b0, 7'd5}},
		'{ilid_pkg::CMD_READ,     7'd127, 32'd0,  1'b1, '{V_NEG1, 1'b0, 7'd5}},
		'{ilid_pkg::CMD_INS_AT,   7'd6,   V_MID,  1'b1, '{32'd0,  1'b0, 7'd5}},
		'{ilid_pkg::CMD_DELETE,   7'd5,   32'd0,  1'b1, '{32'd0,  1'b0, 7'd5}},
		'{ilid_pkg::CMD_DELETE,   7'd127, 32'd0,  1'b1, '{32'd0,  1'b0, 7'd5}},
		'{ilid_pkg::CMD_DELETE,   7'd0,   32'd0,  1'b1, '{32'd0,  1'b1, 7'd4}},
		'{ilid_pkg::CMD_DELETE,   7'd3,   32'd0,  1'b1, '{32'd0,  1'b1, 7'd3}},
		'{ilid_pkg::CMD_READ,     7'd2,   32'd0,  1'b1, '{V_MIN,  1'b1, 7'd3}},
		'{ilid_pkg::CMD_DELETE,   7'd1,   32'd0,  1'b1, '{32'd0,  1'b1, 7'd2}},
		'{ilid_pkg::CMD_READ,     7'd1,   32'd0,  1'b1, '{V_MIN,  1'b1, 7'd2}},
		'{CMD_BAD_MID,            7'd0,   V_MIN,  1'b1, '{32'd0,  1'b0, 7'd2}},
		'{ilid_pkg::CMD_READ,     7'd0,   32'd0,  1'b0, '{32'd0,  1'b0, 7'd0}}
	};

	localparam int TX_IDLE [4] = '{0, 56, 0, 34};
	localparam int RX_STALL [4] = '{0, 0, 56, 34};

	logic clk;
	logic arst_n;

	ilid_req_if req_ch ();
	ilid_rsp_if rsp_ch ();

	indexed_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// behavioral copy of the list
	logic signed [ilid_pkg::VALUE_W-1:0] list_cells [CAPACITY];
	int                                  list_len;
	int                                  list_len_q;

	list_result_t results_due[$];
	logic         drv_typed;
	list_result_t drv_typed_res;

	int items_sent;
	int results_seen;
	int fail_count;
	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic list_result_t apply_list_cmd(logic [ilid_pkg::CMD_W-1:0] op,
			logic [ilid_pkg::POS_W-1:0] pos, logic [ilid_pkg::VALUE_W-1:0] val);
		list_result_t r;
		int           at;
		int           i;
		r = '0;
		at = 0;
		case (op)
			ilid_pkg::CMD_READ: begin
				if (pos < list_len) begin
					r.read_value = list_cells[pos];
					r.accepted = 1'b1;
				end else begin
					r.read_value = -32'sd1;
				end
			end
			ilid_pkg::CMD_INS_HEAD, ilid_pkg::CMD_APPEND, ilid_pkg::CMD_INS_AT: begin
				if (op == ilid_pkg::CMD_INS_HEAD)
					at = 0;
				else if (op == ilid_pkg::CMD_APPEND)
					at = list_len;
				else
					at = pos;
				if (list_len < CAPACITY && at <= list_len) begin
					for (i = list_len; i > at; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[at] = val;
					list_len++;
					r.accepted = 1'b1;
				end
			end
			ilid_pkg::CMD_DELETE: begin
				if (pos < list_len) begin
					for (i = pos; i + 1 < list_len; i++)
						list_cells[i] = list_cells[i+1];
					list_len--;
					r.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = list_len[ilid_pkg::COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [ilid_pkg::VALUE_W-1:0] want,
			logic [ilid_pkg::VALUE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// results are checked before the item taken at the same edge is predicted
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0h %0b %0d", $time,
						rsp_ch.read_value, rsp_ch.accepted, rsp_ch.entry_count);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("read_value", want.read_value, rsp_ch.read_value);
					check_field("accepted", 32'(want.accepted), 32'(rsp_ch.accepted));
					check_field("entry_count", 32'(want.entry_count), 32'(rsp_ch.entry_count));
				end
				results_seen++;
			end
			if (req_ch.valid && req_ch.ready) begin
				want = apply_list_cmd(req_ch.cmd, req_ch.position, req_ch.new_value);
				results_due.push_back(drv_typed ? drv_typed_res : want);
			end
		end
		list_len_q <= list_len;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_item(logic [ilid_pkg::CMD_W-1:0] op, logic [ilid_pkg::POS_W-1:0] pos,
			logic [ilid_pkg::VALUE_W-1:0] val, logic typed, list_result_t want);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.position <= pos;
		req_ch.new_value <= val;
		drv_typed <= typed;
		drv_typed_res <= want;
		do
			@(posedge clk);
		while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic send_random(bit grow);
		logic [ilid_pkg::CMD_W-1:0] op;
		int                         code;
		int                         pos;
		int                         r;
		int                         n;
		n = list_len_q;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// noise: any code, any position
			code = $urandom_range(0, 7);
			op = code[ilid_pkg::CMD_W-1:0];
			pos = $urandom_range(0, 127);
		end else begin
			r = $urandom_range(0, 99);
			if (r < (grow ? 55 : 25)) begin
				case ($urandom_range(0, 2))
					0: op = ilid_pkg::CMD_INS_HEAD;
					1: op = ilid_pkg::CMD_APPEND;
					default: op = ilid_pkg::CMD_INS_AT;
				endcase
				pos = $urandom_range(0, n);
			end else begin
				op = (r < 75) ? ilid_pkg::CMD_DELETE : ilid_pkg::CMD_READ;
				pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
			end
		end
		send_item(op, pos[ilid_pkg::POS_W-1:0], $urandom, 1'b0, '0);
	endtask

	// the last item stays on the bus after it is taken, so drop valid first
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
	endtask

	initial begin
		int ph;
		int fill_pos;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = ilid_pkg::CMD_READ;
		req_ch.position = '0;
		req_ch.new_value = '0;
		drv_typed = 1'b0;
		drv_typed_res = '0;
		list_len = 0;
		list_len_q = 0;
		items_sent = 0;
		results_seen = 0;
		fail_count = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k])
			send_item(DIRECTED[k].op, DIRECTED[k].pos, DIRECTED[k].val,
				DIRECTED[k].typed, DIRECTED[k].want);
		wait_drained();

		// fill to capacity, then poke every insert and the last slot
		repeat (CAPACITY - list_len_q) begin
			fill_pos = $urandom_range(0, 127);
			send_item(ilid_pkg::CMD_APPEND, fill_pos[ilid_pkg::POS_W-1:0], $urandom,
				1'b0, '0);
		end
		send_item(ilid_pkg::CMD_INS_HEAD, 7'd0, V_MAX, 1'b0, '0);
		send_item(ilid_pkg::CMD_APPEND, 7'd0, V_MIN, 1'b0, '0);
		send_item(ilid_pkg::CMD_INS_AT, 7'd0, V_MID, 1'b0, '0);
		send_item(ilid_pkg::CMD_INS_AT, POS_CAP, V_MID, 1'b0, '0);
		send_item(ilid_pkg::CMD_READ, POS_LAST, 32'd0, 1'b0, '0);
		send_item(ilid_pkg::CMD_READ, POS_CAP, 32'd0, 1'b0, '0);
		send_item(ilid_pkg::CMD_DELETE, POS_LAST, 32'd0, 1'b0, '0);
		send_item(ilid_pkg::CMD_INS_AT, POS_LAST, V_NEG1, 1'b0, '0);
		send_item(ilid_pkg::CMD_READ, POS_LAST, 32'd0, 1'b0, '0);
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			tx_idle_pct = TX_IDLE[ph];
			rx_stall_pct = RX_STALL[ph];
			// long receiver hold-off while the sender keeps offering items
			if (ph == 0)
				rx_hold_cycles = 300;
			repeat (130)
				send_random(ph[0]);
			if (ph != 3)
				wait_drained();
		end
		req_ch.valid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, results_due.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
